### hw/rtl/kt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kt_pkg
// Shared types, codes and helpers of the keyed record table.
// ----------------------------------------------------------------------------
package kt_pkg;

  localparam int KT_ENTRIES = 64;
  localparam int KT_COUNT_W = 7;
  localparam int KT_NAME_BYTES = 20;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_LIST    = 2'd2,
    CMD_INVALID = 2'd3
  } kt_cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_INVALID  = 3'd4
  } kt_status_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [63:0]        key_bytes_0_7;
    logic [63:0]        key_bytes_8_15;
    logic [31:0]        key_bytes_16_19;
    logic signed [31:0] record_size;
  } kt_req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [63:0]           out_bytes_0_7;
    logic [63:0]           out_bytes_8_15;
    logic [31:0]           out_bytes_16_19;
    logic signed [31:0]    out_size;
    logic [KT_COUNT_W-1:0] record_count;
    logic                  last;
  } kt_rsp_t;

  typedef struct packed {
    logic [31:0] b16_19;
    logic [63:0] b8_15;
    logic [63:0] b0_7;
  } kt_key_t;

  typedef struct packed {
    kt_key_t     key;
    logic [31:0] size;
  } kt_rec_t;

  // controller to datapath
  typedef struct packed {
    logic                  load_key;
    logic                  mem_we;
    logic                  wr_shift;
    logic                  out_load;
    logic                  out_record;
    logic                  out_last;
    logic [2:0]            out_status;
    logic [KT_COUNT_W-1:0] out_count;
  } kt_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic match;
    logic out_free;
  } kt_sts_t;

  // a name ends at its first zero byte; the last byte is always zero
  function automatic kt_key_t kt_normalize(input logic [63:0] b0, input logic [63:0] b1,
                                           input logic [31:0] b2);
    logic [8*KT_NAME_BYTES-1:0] raw;
    logic [8*KT_NAME_BYTES-1:0] res;
    logic ended;
    kt_key_t k;
    raw = {b2, b1, b0};
    res = '0;
    ended = 1'b0;
    for (int i = 0; i < KT_NAME_BYTES; i++) begin
      if (i == KT_NAME_BYTES - 1 || raw[8*i +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        res[8*i +: 8] = raw[8*i +: 8];
      end
    end
    k.b0_7 = res[63:0];
    k.b8_15 = res[127:64];
    k.b16_19 = res[159:128];
    return k;
  endfunction

endpackage

### hw/rtl/kt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kt_datapath
// Record memory, key register, name compare and the result register.
// ----------------------------------------------------------------------------
module kt_datapath #(
  parameter int ENTRIES = kt_pkg::KT_ENTRIES,
  parameter int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  kt_pkg::kt_req_t req,
  input  kt_pkg::kt_ctl_t ctl,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [IDX_W-1:0] rd_addr,
  output kt_pkg::kt_sts_t sts,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output kt_pkg::kt_rsp_t rsp
);
  import kt_pkg::*;

  kt_rec_t     mem [ENTRIES];
  kt_rec_t     rd_rec;
  kt_key_t     key_reg;
  logic [31:0] size_reg;

  always_ff @(posedge clk) begin
    if (ctl.load_key) begin
      key_reg <= kt_normalize(req.key_bytes_0_7, req.key_bytes_8_15, req.key_bytes_16_19);
      size_reg <= req.record_size;
    end
  end

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.mem_we) begin
      if (ctl.wr_shift) begin
        mem[wr_addr] <= rd_rec;
      end else begin
        mem[wr_addr] <= '{key: key_reg, size: size_reg};
      end
    end
    rd_rec <= mem[rd_addr];
  end

  assign sts.match = (rd_rec.key == key_reg);
  assign sts.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rsp.status <= ctl.out_status;
      rsp.record_count <= ctl.out_count;
      rsp.last <= ctl.out_last;
      if (ctl.out_record) begin
        rsp.out_bytes_0_7 <= rd_rec.key.b0_7;
        rsp.out_bytes_8_15 <= rd_rec.key.b8_15;
        rsp.out_bytes_16_19 <= rd_rec.key.b16_19;
        rsp.out_size <= rd_rec.size;
      end else begin
        rsp.out_bytes_0_7 <= '0;
        rsp.out_bytes_8_15 <= '0;
        rsp.out_bytes_16_19 <= '0;
        rsp.out_size <= '0;
      end
    end
  end

endmodule

### hw/rtl/kt_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kt_controller
// Command sequencer: dispatch, delete scan with in-place compaction, list walk.
// ----------------------------------------------------------------------------
module kt_controller #(
  parameter int ENTRIES = kt_pkg::KT_ENTRIES,
  parameter int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [1:0]       req_cmd,
  output logic             req_stall,
  input  kt_pkg::kt_sts_t  sts,
  output kt_pkg::kt_ctl_t  ctl,
  output logic [IDX_W-1:0] wr_addr,
  output logic [IDX_W-1:0] rd_addr
);
  import kt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_DEL  = 5'b00100,
    S_DONE = 5'b01000,
    S_LIST = 5'b10000
  } state_t;

  state_t           state, state_next;
  kt_cmd_e          cmd, cmd_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] count, count_next;
  logic             found, found_next;
  logic             at_end;

  assign req_stall = (state != S_IDLE);
  assign at_end = ((CNT_W'(idx) + CNT_W'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd <= CMD_INVALID;
      idx <= '0;
      count <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      cmd <= cmd_next;
      idx <= idx_next;
      count <= count_next;
      found <= found_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_next = cmd;
    idx_next = idx;
    count_next = count;
    found_next = found;
    ctl = '0;
    ctl.out_count = KT_COUNT_W'(count);
    wr_addr = count[IDX_W-1:0];
    rd_addr = idx;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd_next = kt_cmd_e'(req_cmd);
          ctl.load_key = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd)
          CMD_CREATE: begin
            if (sts.out_free) begin
              ctl.out_load = 1'b1;
              ctl.out_last = 1'b1;
              state_next = S_IDLE;
              if (count == CNT_W'(ENTRIES)) begin
                ctl.out_status = ST_FULL;
              end else begin
                ctl.mem_we = 1'b1;
                count_next = count + CNT_W'(1);
                ctl.out_count = KT_COUNT_W'(count_next);
                ctl.out_status = ST_OK;
              end
            end
          end
          CMD_DELETE, CMD_LIST: begin
            if (count == '0) begin
              if (sts.out_free) begin
                ctl.out_load = 1'b1;
                ctl.out_last = 1'b1;
                ctl.out_status = ST_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              idx_next = '0;
              found_next = 1'b0;
              rd_addr = '0;
              state_next = (cmd == CMD_DELETE) ? S_DEL : S_LIST;
            end
          end
          CMD_INVALID: begin
            if (sts.out_free) begin
              ctl.out_load = 1'b1;
              ctl.out_last = 1'b1;
              ctl.out_status = ST_INVALID;
              state_next = S_IDLE;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_DEL: begin
        // records after the match move down one place as the scan passes
        if (found) begin
          ctl.mem_we = 1'b1;
          ctl.wr_shift = 1'b1;
        end
        wr_addr = idx - IDX_W'(1);
        found_next = found | sts.match;
        if (at_end) begin
          state_next = S_DONE;
        end else begin
          idx_next = idx + IDX_W'(1);
          rd_addr = idx_next;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_last = 1'b1;
          if (found) begin
            ctl.out_status = ST_OK;
            count_next = count - CNT_W'(1);
          end else begin
            ctl.out_status = ST_NOTFOUND;
          end
          ctl.out_count = KT_COUNT_W'(count_next);
          state_next = S_IDLE;
        end
      end
      S_LIST: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_record = 1'b1;
          ctl.out_status = ST_OK;
          ctl.out_last = at_end;
          if (at_end) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
            rd_addr = idx_next;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/keyed_table_with_compacting_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_table_with_compacting_delete
// Ordered table of named records with create, compacting delete and list.
// ----------------------------------------------------------------------------
// create and invalid commands: the result is loaded in S_EXEC once the result register is free
// delete: the scan reads each stored record in turn through the single memory read port,
//   then S_DONE loads the result once the result register is free; no new command is taken meanwhile
// list: records are loaded in order from S_LIST, one record per cycle while the result register is free
// reset clears the record count and control state; record memory is not cleared
// ----------------------------------------------------------------------------
module keyed_table_with_compacting_delete #(
  parameter int ENTRIES = kt_pkg::KT_ENTRIES
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  kt_pkg::kt_req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output kt_pkg::kt_rsp_t rsp
);
  import kt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  kt_ctl_t          ctl;
  kt_sts_t          sts;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;

  kt_controller #(
    .ENTRIES(ENTRIES),
    .IDX_W  (IDX_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_cmd  (req.cmd),
    .req_stall(req_stall),
    .sts      (sts),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr)
  );

  kt_datapath #(
    .ENTRIES(ENTRIES),
    .IDX_W  (IDX_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .sts      (sts),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> sts.out_free)
    else $error("result register overwritten while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("input taken again before command ran");

  a_busy_mid_list: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load && !ctl.out_last |=> req_stall)
    else $error("input taken in the middle of a list");

  a_shift_only_writes: assert property (@(posedge clk) disable iff (rst)
    ctl.mem_we && ctl.wr_shift |-> !ctl.out_load)
    else $error("compaction write during a result load");
`endif

endmodule
